>>> design/bpa_pkg.sv
package bpa_pkg;
    localparam int MAP_WORDS      = 1024;
    localparam int RECORD_ENTRIES = 512;
    localparam int RESERVED_WORDS = 16;
    localparam int MAP_AW         = $clog2(MAP_WORDS);
    localparam int REC_AW         = $clog2(RECORD_ENTRIES);
    localparam int PAGE_W         = MAP_AW + 5;
    localparam int CNT_W          = REC_AW + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_RUN   = 2'd1;
    localparam logic [1:0] ST_MISALIGN = 2'd2;
    localparam logic [1:0] ST_TBL_FULL = 2'd3;

    typedef struct packed {
        logic [26:0] granted_address;
        logic [15:0] pages_freed;
        logic [1:0]  status;
    } result_t;
endpackage

>>> design/bitmap_page_allocator.sv
// Allocate reads each bitmap word from word 16, then scans one byte of the word per
// cycle, then reads and marks each word of the run found; free searches the record
// entries, moves the last entry into the freed slot, then reads and clears each word.
// The item is accepted in S_IDLE and the result is raised from S_OUT.
// One item is worked at a time; the next is taken only after the result is accepted.
// Reset: synchronous active-low; a clearing pass over all MAP_WORDS words rebuilds the
// bitmap (reserved words all ones) and the kernel record while no item is accepted.
module bitmap_page_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // page_count[15:0], keep_record[16], address[48:17]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // granted_address[26:0], pages_freed[42:27], status[44:43]
);
    import bpa_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SREAD = 4'd2, S_SCAN = 4'd3,
                           S_MREAD = 4'd4, S_MWRITE = 4'd5, S_FREAD = 4'd6, S_FCMP = 4'd7,
                           S_LREAD = 4'd8, S_LWAIT = 4'd9, S_OUT = 4'd10;

    logic [31:0] map_mem [MAP_WORDS];
    logic [PAGE_W-1:0] rs_mem [RECORD_ENTRIES];
    logic [15:0] rl_mem [RECORD_ENTRIES];

    logic [3:0] state_reg, state_next;
    logic [10:0] wiu_reg;
    logic [CNT_W-1:0] rcnt_reg;
    logic [MAP_AW:0] widx_reg;
    logic [1:0] sub_reg;
    logic [REC_AW:0] ridx_reg;
    logic [31:0] map_q;
    logic [PAGE_W-1:0] rs_q;
    logic [15:0] rl_q;
    logic mode_reg, keep_reg;
    logic [15:0] count_reg;
    logic [19:0] page_reg;
    logic [16:0] run_reg;
    logic [PAGE_W:0] found_reg;
    logic [16:0] left_reg;
    logic [REC_AW-1:0] hit_reg;
    result_t res_reg;
    logic out_v_reg;

    logic        map_we, rs_we;
    logic [MAP_AW-1:0] map_wa, map_ra;
    logic [31:0] map_wd;
    logic [REC_AW-1:0] rs_wa, rs_ra;
    logic [PAGE_W-1:0] rs_wd;
    logic [15:0] rl_wd;

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_wa] <= map_wd;
        map_q <= map_mem[map_ra];
        if (rs_we) begin
            rs_mem[rs_wa] <= rs_wd;
            rl_mem[rs_wa] <= rl_wd;
        end
        rs_q <= rs_mem[rs_ra];
        rl_q <= rl_mem[rs_ra];
    end

    logic [MAP_AW:0] words_lim;
    assign words_lim = (wiu_reg > 11'(MAP_WORDS)) ? (MAP_AW+1)'(MAP_WORDS)
                                                   : (MAP_AW+1)'(wiu_reg);

    // word scan: one byte of the word per cycle, run carried across bytes and words
    logic [16:0] run_w;
    logic        hit_w;
    logic [4:0]  hit_bit;
    always_comb begin
        logic [16:0] r;
        r = run_reg; hit_w = 1'b0; hit_bit = '0;
        for (int j = 0; j < 8; j++) begin
            if (!hit_w) begin
                r = map_q[{sub_reg, 3'(j)}] ? 17'd0 : r + 17'd1;
                if (r == {1'b0, count_reg}) begin
                    hit_w = 1'b1; hit_bit = {sub_reg, 3'(j)};
                end
            end
        end
        run_w = r;
    end

    // mask for the run part inside current word
    logic [5:0] bit_lo;
    logic [31:0] run_mask;
    logic [5:0] nbits;
    always_comb begin
        bit_lo = {1'b0, page_reg[4:0]};
        nbits = (left_reg > 17'(32 - bit_lo)) ? 6'(32 - bit_lo) : left_reg[5:0];
        run_mask = (nbits == 6'd32) ? 32'hFFFF_FFFF
                 : ((32'd1 << nbits) - 32'd1) << bit_lo[4:0];
    end

    logic s_fire;
    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        map_we = 1'b0; map_wa = widx_reg[MAP_AW-1:0]; map_wd = '0;
        map_ra = widx_reg[MAP_AW-1:0];
        rs_we = 1'b0; rs_wa = ridx_reg[REC_AW-1:0]; rs_wd = '0; rl_wd = '0;
        rs_ra = ridx_reg[REC_AW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wd = (widx_reg < (MAP_AW+1)'(RESERVED_WORDS)) ? 32'hFFFF_FFFF : 32'h0;
                // kernel record goes into entry 0 on the first step
                if (widx_reg == '0) begin
                    rs_we = 1'b1;
                    rs_wa = '0;
                    rs_wd = '0;
                    rl_wd = 16'(RESERVED_WORDS * 32);
                end
                if (widx_reg == (MAP_AW+1)'(MAP_WORDS-1)) state_next = S_IDLE;
            end
            S_IDLE: ;
            S_SREAD: state_next = S_SCAN;
            S_SCAN: ;
            S_MREAD: begin
                map_ra = page_reg[PAGE_W-1:5];
                state_next = S_MWRITE;
            end
            S_MWRITE: begin
                map_wa = page_reg[PAGE_W-1:5];
                map_we = (page_reg[19:5] < 15'(MAP_WORDS));
                map_wd = mode_reg ? (map_q & ~run_mask) : (map_q | run_mask);
                // record a kept allocation with its last word
                if (left_reg == 17'(nbits) && !mode_reg && keep_reg) begin
                    rs_we = 1'b1;
                    rs_wa = rcnt_reg[REC_AW-1:0];
                    rs_wd = PAGE_W'(found_reg);
                    rl_wd = count_reg;
                end
            end
            S_FREAD: state_next = S_FCMP;
            S_FCMP: ;
            S_LREAD: begin
                rs_ra = REC_AW'(rcnt_reg - CNT_W'(1));
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                rs_we = 1'b1;
                rs_wa = hit_reg; rs_wd = rs_q; rl_wd = rl_q;
            end
            S_OUT: ;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            widx_reg <= '0;
            wiu_reg <= 11'd1024;
            rcnt_reg <= CNT_W'(1);
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) wiu_reg <= cfg_wr_data;
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR: begin
                    widx_reg <= widx_reg + 1'b1;
                    state_reg <= state_next;
                end
                S_SREAD, S_MREAD, S_FREAD, S_LREAD: state_reg <= state_next;
                S_IDLE: if (s_fire) begin
                    mode_reg <= s_tuser;
                    count_reg <= s_tdata[15:0];
                    keep_reg <= s_tdata[16];
                    res_reg.granted_address <= '0;
                    res_reg.pages_freed <= '0;
                    run_reg <= '0;
                    widx_reg <= (MAP_AW+1)'(RESERVED_WORDS);
                    sub_reg <= 2'd0;
                    ridx_reg <= '0;
                    page_reg <= s_tdata[48:29];
                    if (!s_tuser) begin
                        if (s_tdata[16] && rcnt_reg >= CNT_W'(RECORD_ENTRIES)) begin
                            res_reg.status <= ST_TBL_FULL; state_reg <= S_OUT;
                        end else if (s_tdata[15:0] == 16'd0 ||
                                     words_lim <= (MAP_AW+1)'(RESERVED_WORDS)) begin
                            res_reg.status <= ST_NO_RUN; state_reg <= S_OUT;
                        end else begin
                            res_reg.status <= ST_OK; state_reg <= S_SREAD;
                        end
                    end else begin
                        if (s_tdata[28:17] != 12'd0) begin
                            res_reg.status <= ST_MISALIGN; state_reg <= S_OUT;
                        end else if (s_tdata[48:29] == 20'd0) begin
                            res_reg.status <= ST_OK; state_reg <= S_OUT;
                        end else begin
                            res_reg.status <= ST_OK; state_reg <= S_FREAD;
                        end
                    end
                end
                S_SCAN: begin
                    run_reg <= run_w;
                    if (hit_w) begin
                        found_reg <= (PAGE_W+1)'({widx_reg, hit_bit} + (PAGE_W+1)'(1)
                                                 - (PAGE_W+1)'(count_reg));
                        page_reg <= 20'({widx_reg, hit_bit} + (PAGE_W+1)'(1)
                                        - (PAGE_W+1)'(count_reg));
                        left_reg <= {1'b0, count_reg};
                        state_reg <= S_MREAD;
                    end else if (sub_reg != 2'd3) begin
                        sub_reg <= sub_reg + 2'd1;
                    end else if (widx_reg + 1'b1 >= words_lim) begin
                        res_reg.status <= ST_NO_RUN; state_reg <= S_OUT;
                    end else begin
                        widx_reg <= widx_reg + 1'b1;
                        sub_reg <= 2'd0;
                        state_reg <= S_SREAD;
                    end
                end
                S_MWRITE: begin
                    left_reg <= left_reg - 17'(nbits);
                    page_reg <= page_reg + 20'(nbits);
                    if (left_reg == 17'(nbits)) begin
                        state_reg <= S_OUT;
                        if (!mode_reg) begin
                            res_reg.granted_address <= 27'({found_reg, 12'd0});
                            if (keep_reg) rcnt_reg <= rcnt_reg + 1'b1;
                        end
                    end else state_reg <= S_MREAD;
                end
                S_FCMP: begin
                    if (20'(rs_q) == page_reg && rs_q != '0 || 20'(rs_q) == page_reg
                        && ridx_reg != '0) begin
                        hit_reg <= ridx_reg[REC_AW-1:0];
                        res_reg.pages_freed <= rl_q;
                        left_reg <= {1'b0, rl_q};
                        state_reg <= S_LREAD;
                    end else if ((CNT_W)'(ridx_reg + 1'b1) >= rcnt_reg) state_reg <= S_OUT;
                    else begin
                        ridx_reg <= ridx_reg + 1'b1; state_reg <= S_FREAD;
                    end
                end
                S_LWAIT: begin
                    rcnt_reg <= rcnt_reg - 1'b1;
                    state_reg <= (left_reg == '0) ? S_OUT : S_MREAD;
                end
                S_OUT: begin
                    out_v_reg <= 1'b1; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {3'b0, res_reg.status, res_reg.pages_freed, res_reg.granted_address};
endmodule
